/* design/sci_pkg.sv */
package sci_pkg;

    localparam int COORD_W   = 32;
    localparam int FRAC_BITS = 16;
    localparam int NORM_FRAC = 14;
    localparam int RADIUS_W  = 31;
    localparam logic [RADIUS_W-1:0] RADIUS_RESET = RADIUS_W'(65536);

    // Derived widths of the exact intermediate values.
    localparam int DIFF_W  = COORD_W + 1;              // end - begin
    localparam int SQ_W    = 2 * COORD_W;              // squares, |B|, C magnitude, N
    localparam int HALF_W  = SQ_W / 2;                 // split point for wide products
    localparam int A_W     = SQ_W + 1;                 // d.d
    localparam int B_W     = SQ_W + 1;                 // begin.d, signed
    localparam int RR_W    = 2 * RADIUS_W;             // radius squared
    localparam int BSQ_W   = 2 * SQ_W;                 // B squared
    localparam int AC_W    = A_W + SQ_W;               // A times |C|
    localparam int D_W     = 2 * SQ_W + 1;             // discriminant
    localparam int ROOT_W  = (D_W + 1) / 2;            // integer square root
    localparam int T_W     = FRAC_BITS + 2;            // root parameter t
    localparam int NN_W    = SQ_W + FRAC_BITS;         // N scaled by 2^FRAC_BITS
    localparam int LIM_W   = A_W + FRAC_BITS + 1;      // A * (2^FRAC_BITS + 2)
    localparam int LERP_W  = T_W + 1 + DIFF_W;         // t * d
    localparam int NORM_W  = 16;                       // Q2.14 normal
    localparam int NN_BITS = NORM_FRAC + 1;            // normal magnitude bits
    localparam int NR_W    = SQ_W + 2 * NORM_FRAC;     // |c|^2 scaled by 2^(2*NORM_FRAC)
    localparam int NP_W    = SQ_W + NN_BITS;           // n * |p|^2
    localparam int NT_W    = NR_W + 3;                 // normal trial value

    typedef struct packed {
        logic                miss;
        logic                bneg;
        logic [SQ_W-1:0]     bmag;
        logic [A_W-1:0]      a;
        logic [COORD_W-1:0]  bx;
        logic [COORD_W-1:0]  by;
        logic [DIFF_W-1:0]   dx;
        logic [DIFF_W-1:0]   dy;
    } t_sq_side;

endpackage

/* design/sci_seg_if.sv */
interface sci_seg_if import sci_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [COORD_W-1:0]  begin_x;
    logic signed [COORD_W-1:0]  begin_y;
    logic signed [COORD_W-1:0]  end_x;
    logic signed [COORD_W-1:0]  end_y;

    modport source (output valid, output begin_x, output begin_y, output end_x,
                    output end_y, input ready);
    modport sink (input valid, input begin_x, input begin_y, input end_x,
                  input end_y, output ready);
endinterface

/* design/sci_res_if.sv */
interface sci_res_if import sci_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic                       hit;
    logic signed [COORD_W-1:0]  point_x;
    logic signed [COORD_W-1:0]  point_y;
    logic signed [NORM_W-1:0]   normal_x;
    logic signed [NORM_W-1:0]   normal_y;

    modport source (output valid, output hit, output point_x, output point_y,
                    output normal_x, output normal_y, input ready);
    modport sink (input valid, input hit, input point_x, input point_y,
                  input normal_x, input normal_y, output ready);
endinterface

/* design/sci_sqrt.sv */
module sci_sqrt import sci_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [D_W-1:0]    i_rad,
    input  t_sq_side          i_side,
    output logic              o_valid,
    output logic [ROOT_W-1:0] o_root,
    output t_sq_side          o_side
);

    localparam int TR_W = D_W + 1;

    logic [ROOT_W-1:0] r_v;
    logic [D_W-1:0]    r_rem  [0:ROOT_W-1];
    logic [ROOT_W-1:0] r_root [0:ROOT_W-1];
    t_sq_side          r_side [0:ROOT_W-1];

    logic [D_W-1:0]    c_in_rem  [0:ROOT_W-1];
    logic [ROOT_W-1:0] c_in_root [0:ROOT_W-1];
    logic [D_W-1:0]    c_rem     [0:ROOT_W-1];
    logic [ROOT_W-1:0] c_root    [0:ROOT_W-1];

    // One result bit per stage, most significant first. The remainder holds
    // rad - root^2 and the trial value is (root + 2^k)^2 - root^2.
    always_comb begin
        logic [TR_W-1:0] trial;
        c_in_rem[0]  = i_rad;
        c_in_root[0] = '0;
        for (int j = 1; j < ROOT_W; j++) begin
            c_in_rem[j]  = r_rem[j-1];
            c_in_root[j] = r_root[j-1];
        end
        for (int j = 0; j < ROOT_W; j++) begin
            trial = (TR_W'(c_in_root[j]) << (ROOT_W - j))
                  | (TR_W'(1) << (2 * (ROOT_W - 1 - j)));
            c_rem[j]  = c_in_rem[j];
            c_root[j] = c_in_root[j];
            if (trial <= TR_W'(c_in_rem[j])) begin
                c_rem[j]  = c_in_rem[j] - trial[D_W-1:0];
                c_root[j] = c_in_root[j] | (ROOT_W'(1) << (ROOT_W - 1 - j));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[ROOT_W-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side[0] <= i_side;
            for (int j = 0; j < ROOT_W; j++) begin
                r_rem[j]  <= c_rem[j];
                r_root[j] <= c_root[j];
            end
            for (int j = 1; j < ROOT_W; j++) begin
                r_side[j] <= r_side[j-1];
            end
        end
    end

    assign o_valid = r_v[ROOT_W-1];
    assign o_root  = r_root[ROOT_W-1];
    assign o_side  = r_side[ROOT_W-1];

endmodule

/* design/segment_circle_intersection.sv */
// Segment against circle test, circle centered at the origin.
// Input channel i_seg carries one segment per transaction: begin and end
// points in signed Q16.16. Output channel o_res carries one result per
// segment, in order: hit flag, entry point (Q16.16) and unit normal (Q2.14);
// every field is zero on a miss.
// The radius (unsigned Q15.16) is written through i_cfg_we / i_cfg_wdata and
// should only change while no segment is in flight.
// The block is one pipeline of 112 register stages; all but the output register
// share a single advance enable, so a new segment is taken every cycle while
// i_seg.ready is high. The depth is set by the 65-stage square root of the
// discriminant, the 18-stage divider for t and the 15-stage normal search.
// When the receiver holds ready low, the result waits in the output register;
// the pipeline keeps moving while its last stage is empty and freezes
// otherwise, so i_seg.ready falls only then. Nothing is dropped or repeated.
// Synchronous active-low reset clears all valid bits and sets the radius to
// 1.0; no clearing pass is needed.
module segment_circle_intersection import sci_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [RADIUS_W-1:0] i_cfg_wdata,
    sci_seg_if.sink             i_seg,
    sci_res_if.source           o_res
);

    localparam int NS = NN_BITS;

    typedef struct packed {
        logic                miss;
        logic [A_W-1:0]      a;
        logic [NN_W-1:0]     rem;
        logic [T_W-1:0]      t;
        logic [COORD_W-1:0]  bx;
        logic [COORD_W-1:0]  by;
        logic [DIFF_W-1:0]   dx;
        logic [DIFF_W-1:0]   dy;
    } t_dv;

    typedef struct packed {
        logic                miss;
        logic                lzero;
        logic [COORD_W-1:0]  px;
        logic [COORD_W-1:0]  py;
        logic [SQ_W-1:0]     len2;
        logic [NR_W-1:0]     rx;
        logic [NR_W-1:0]     ry;
        logic [NP_W-1:0]     ppx;
        logic [NP_W-1:0]     ppy;
        logic [NN_BITS-1:0]  nx;
        logic [NN_BITS-1:0]  ny;
    } t_nm;

    logic w_en;
    logic w_last_valid;

    logic [RADIUS_W-1:0] r_radius;

    // Stage 1: operands and differences.
    logic                      r_v1;
    logic signed [COORD_W-1:0] r1_bx, r1_by;
    logic signed [DIFF_W-1:0]  r1_dx, r1_dy;

    // Stage 2: squares and cross products.
    logic                      r_v2;
    logic [SQ_W-1:0]           r2_dxx, r2_dyy, r2_bxx, r2_byy;
    logic signed [SQ_W-1:0]    r2_bxd, r2_byd;
    logic [RR_W-1:0]           r2_rr;
    logic signed [COORD_W-1:0] r2_bx, r2_by;
    logic signed [DIFF_W-1:0]  r2_dx, r2_dy;
    logic signed [2*DIFF_W-1:0] c2_dxx, c2_dyy;
    logic signed [SQ_W-1:0]    c2_bxx, c2_byy;
    logic signed [B_W-1:0]     c2_bxd, c2_byd;

    // Stage 3: A, B and |begin|^2.
    logic                      r_v3;
    logic [A_W-1:0]            r3_a;
    logic signed [B_W-1:0]     r3_b;
    logic [SQ_W-1:0]           r3_cpos;
    logic [RR_W-1:0]           r3_rr;
    logic signed [COORD_W-1:0] r3_bx, r3_by;
    logic signed [DIFF_W-1:0]  r3_dx, r3_dy;
    logic signed [B_W-1:0]     c3_b;

    // Stage 4: sign and magnitude of B and C.
    logic                      r_v4;
    logic                      r4_cneg, r4_bneg, r4_azero;
    logic [SQ_W-1:0]           r4_cm, r4_bmag;
    logic [A_W-1:0]            r4_a;
    logic signed [COORD_W-1:0] r4_bx, r4_by;
    logic signed [DIFF_W-1:0]  r4_dx, r4_dy;
    logic signed [B_W-1:0]     c4_bneg_val;
    logic                      c4_cneg;

    // Stage 5: partial products of B^2 and A*|C|.
    logic                      r_v5;
    logic [SQ_W-1:0]           r5_bhh, r5_bhl, r5_bll, r5_alh, r5_all;
    logic [A_W-1:0]            r5_ahh, r5_ahl;
    logic                      r5_cneg, r5_bneg, r5_azero;
    logic [SQ_W-1:0]           r5_bmag;
    logic [A_W-1:0]            r5_a;
    logic signed [COORD_W-1:0] r5_bx, r5_by;
    logic signed [DIFF_W-1:0]  r5_dx, r5_dy;

    // Stage 6: full products.
    logic                      r_v6;
    logic [BSQ_W-1:0]          r6_bsq;
    logic [AC_W-1:0]           r6_ac;
    logic                      r6_cneg, r6_bneg, r6_azero;
    logic [SQ_W-1:0]           r6_bmag;
    logic [A_W-1:0]            r6_a;
    logic signed [COORD_W-1:0] r6_bx, r6_by;
    logic signed [DIFF_W-1:0]  r6_dx, r6_dy;

    // Stage 7: discriminant.
    logic                      r_v7;
    logic [D_W-1:0]            r7_d;
    t_sq_side                  r7_side;
    logic                      c7_lt;

    // Square root outputs.
    logic                      w_sq_valid;
    logic [ROOT_W-1:0]         w_root;
    t_sq_side                  w_sq_side;

    // Stage 8: entering root numerator and limit.
    logic                      r_v8;
    logic                      r8_miss;
    logic [SQ_W-1:0]           r8_n;
    logic [LIM_W-1:0]          r8_lim;
    logic [A_W-1:0]            r8_a;
    logic [COORD_W-1:0]        r8_bx, r8_by;
    logic [DIFF_W-1:0]         r8_dx, r8_dy;
    logic                      c8_miss;
    logic [SQ_W-1:0]           c8_n;

    // Stage 9 and the divider stages.
    logic [T_W:0]              r_dvv;
    t_dv                       r_dv [0:T_W];
    t_dv                       c_dv [0:T_W-1];
    t_dv                       c9_dv;
    logic [NN_W-1:0]           c9_nn;

    // Stage 10 and 11: interpolation and saturation.
    logic                      r_v10;
    logic                      r10_miss;
    logic signed [LERP_W-1:0]  r10_tx, r10_ty;
    logic signed [COORD_W-1:0] r10_bx, r10_by;
    logic                      r_v11;
    logic                      r11_miss;
    logic signed [COORD_W-1:0] r11_px, r11_py;
    logic signed [LERP_W-1:0]  c11_vx, c11_vy;
    logic signed [COORD_W-1:0] c11_px, c11_py;

    // Stage 12: squares of the point.
    logic                      r_v12;
    logic                      r12_miss;
    logic [SQ_W-1:0]           r12_sqx, r12_sqy;
    logic signed [COORD_W-1:0] r12_px, r12_py;
    logic signed [SQ_W-1:0]    c12_sqx, c12_sqy;

    // Stage 13 and the normal stages.
    logic [NS:0]               r_nmv;
    t_nm                       r_nm [0:NS];
    t_nm                       c_nm [0:NS-1];
    t_nm                       c13_nm;

    // Output register.
    logic                      r_out_valid;
    logic                      r_out_hit;
    logic signed [COORD_W-1:0] r_out_px, r_out_py;
    logic signed [NORM_W-1:0]  r_out_nx, r_out_ny;
    logic                      w_out_load;
    logic signed [NORM_W-1:0]  c_out_nx, c_out_ny;

    assign w_last_valid = r_nmv[NS];
    assign w_out_load   = !r_out_valid || o_res.ready;
    assign w_en         = w_out_load || !w_last_valid;
    assign i_seg.ready  = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= RADIUS_RESET;
        end else if (i_cfg_we) begin
            r_radius <= i_cfg_wdata;
        end
    end

    // Valid bits travel with the data and move only on the shared enable.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1  <= 1'b0;
            r_v2  <= 1'b0;
            r_v3  <= 1'b0;
            r_v4  <= 1'b0;
            r_v5  <= 1'b0;
            r_v6  <= 1'b0;
            r_v7  <= 1'b0;
            r_v8  <= 1'b0;
            r_dvv <= '0;
            r_v10 <= 1'b0;
            r_v11 <= 1'b0;
            r_v12 <= 1'b0;
            r_nmv <= '0;
        end else if (w_en) begin
            r_v1  <= i_seg.valid;
            r_v2  <= r_v1;
            r_v3  <= r_v2;
            r_v4  <= r_v3;
            r_v5  <= r_v4;
            r_v6  <= r_v5;
            r_v7  <= r_v6;
            r_v8  <= w_sq_valid;
            r_dvv <= {r_dvv[T_W-1:0], r_v8};
            r_v10 <= r_dvv[T_W];
            r_v11 <= r_v10;
            r_v12 <= r_v11;
            r_nmv <= {r_nmv[NS-1:0], r_v12};
        end
    end

    assign c2_dxx = (2*DIFF_W)'(r1_dx) * (2*DIFF_W)'(r1_dx);
    assign c2_dyy = (2*DIFF_W)'(r1_dy) * (2*DIFF_W)'(r1_dy);
    assign c2_bxx = SQ_W'(r1_bx) * SQ_W'(r1_bx);
    assign c2_byy = SQ_W'(r1_by) * SQ_W'(r1_by);
    assign c2_bxd = B_W'(r1_bx) * B_W'(r1_dx);
    assign c2_byd = B_W'(r1_by) * B_W'(r1_dy);

    assign c3_b = B_W'(r2_bxd) + B_W'(r2_byd);

    assign c4_cneg     = r3_cpos < SQ_W'(r3_rr);
    assign c4_bneg_val = -r3_b;

    assign c7_lt = AC_W'(r6_bsq) < r6_ac;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_bx <= i_seg.begin_x;
            r1_by <= i_seg.begin_y;
            r1_dx <= DIFF_W'(i_seg.end_x) - DIFF_W'(i_seg.begin_x);
            r1_dy <= DIFF_W'(i_seg.end_y) - DIFF_W'(i_seg.begin_y);

            r2_dxx <= c2_dxx[SQ_W-1:0];
            r2_dyy <= c2_dyy[SQ_W-1:0];
            r2_bxx <= c2_bxx;
            r2_byy <= c2_byy;
            r2_bxd <= c2_bxd[SQ_W-1:0];
            r2_byd <= c2_byd[SQ_W-1:0];
            r2_rr  <= RR_W'(r_radius) * RR_W'(r_radius);
            r2_bx  <= r1_bx;
            r2_by  <= r1_by;
            r2_dx  <= r1_dx;
            r2_dy  <= r1_dy;

            r3_a    <= A_W'(r2_dxx) + A_W'(r2_dyy);
            r3_b    <= c3_b;
            r3_cpos <= r2_bxx + r2_byy;
            r3_rr   <= r2_rr;
            r3_bx   <= r2_bx;
            r3_by   <= r2_by;
            r3_dx   <= r2_dx;
            r3_dy   <= r2_dy;

            r4_cneg  <= c4_cneg;
            r4_cm    <= c4_cneg ? SQ_W'(r3_rr) - r3_cpos : r3_cpos - SQ_W'(r3_rr);
            r4_bneg  <= r3_b[B_W-1];
            r4_bmag  <= r3_b[B_W-1] ? c4_bneg_val[SQ_W-1:0] : r3_b[SQ_W-1:0];
            r4_azero <= (r3_a == '0);
            r4_a     <= r3_a;
            r4_bx    <= r3_bx;
            r4_by    <= r3_by;
            r4_dx    <= r3_dx;
            r4_dy    <= r3_dy;

            r5_bhh   <= SQ_W'(r4_bmag[SQ_W-1:HALF_W]) * SQ_W'(r4_bmag[SQ_W-1:HALF_W]);
            r5_bhl   <= SQ_W'(r4_bmag[SQ_W-1:HALF_W]) * SQ_W'(r4_bmag[HALF_W-1:0]);
            r5_bll   <= SQ_W'(r4_bmag[HALF_W-1:0]) * SQ_W'(r4_bmag[HALF_W-1:0]);
            r5_ahh   <= A_W'(r4_a[A_W-1:HALF_W]) * A_W'(r4_cm[SQ_W-1:HALF_W]);
            r5_ahl   <= A_W'(r4_a[A_W-1:HALF_W]) * A_W'(r4_cm[HALF_W-1:0]);
            r5_alh   <= SQ_W'(r4_a[HALF_W-1:0]) * SQ_W'(r4_cm[SQ_W-1:HALF_W]);
            r5_all   <= SQ_W'(r4_a[HALF_W-1:0]) * SQ_W'(r4_cm[HALF_W-1:0]);
            r5_cneg  <= r4_cneg;
            r5_bneg  <= r4_bneg;
            r5_azero <= r4_azero;
            r5_bmag  <= r4_bmag;
            r5_a     <= r4_a;
            r5_bx    <= r4_bx;
            r5_by    <= r4_by;
            r5_dx    <= r4_dx;
            r5_dy    <= r4_dy;

            r6_bsq   <= (BSQ_W'(r5_bhh) << SQ_W) + (BSQ_W'(r5_bhl) << (HALF_W + 1))
                      + BSQ_W'(r5_bll);
            r6_ac    <= (AC_W'(r5_ahh) << SQ_W)
                      + ((AC_W'(r5_ahl) + AC_W'(r5_alh)) << HALF_W) + AC_W'(r5_all);
            r6_cneg  <= r5_cneg;
            r6_bneg  <= r5_bneg;
            r6_azero <= r5_azero;
            r6_bmag  <= r5_bmag;
            r6_a     <= r5_a;
            r6_bx    <= r5_bx;
            r6_by    <= r5_by;
            r6_dx    <= r5_dx;
            r6_dy    <= r5_dy;

            r7_d         <= r6_cneg ? D_W'(r6_bsq) + D_W'(r6_ac) : D_W'(r6_bsq) - D_W'(r6_ac);
            r7_side.miss <= r6_azero || (!r6_cneg && c7_lt);
            r7_side.bneg <= r6_bneg;
            r7_side.bmag <= r6_bmag;
            r7_side.a    <= r6_a;
            r7_side.bx   <= r6_bx;
            r7_side.by   <= r6_by;
            r7_side.dx   <= r6_dx;
            r7_side.dy   <= r6_dy;
        end
    end

    sci_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_v7),
        .i_rad   (r7_d),
        .i_side  (r7_side),
        .o_valid (w_sq_valid),
        .o_root  (w_root),
        .o_side  (w_sq_side)
    );

    // The entering root needs B negative and sqrt(D) <= |B|; with B = 0 only a
    // tangent through begin (D = 0) gives t = 0.
    always_comb begin
        if (w_sq_side.bneg) begin
            c8_miss = w_sq_side.miss || (w_root > ROOT_W'(w_sq_side.bmag));
            c8_n    = w_sq_side.bmag - w_root[SQ_W-1:0];
        end else begin
            c8_miss = w_sq_side.miss || (w_sq_side.bmag != '0) || (w_root != '0);
            c8_n    = '0;
        end
    end

    always_comb begin
        c9_nn       = NN_W'(r8_n) << FRAC_BITS;
        c9_dv.miss  = r8_miss || (LIM_W'(c9_nn) >= r8_lim);
        c9_dv.a     = r8_a;
        c9_dv.rem   = c9_nn;
        c9_dv.t     = '0;
        c9_dv.bx    = r8_bx;
        c9_dv.by    = r8_by;
        c9_dv.dx    = r8_dx;
        c9_dv.dy    = r8_dy;
    end

    // Restoring division of N * 2^FRAC_BITS by A, one quotient bit per stage.
    always_comb begin
        logic [LIM_W-1:0] trial;
        for (int j = 0; j < T_W; j++) begin
            trial   = LIM_W'(r_dv[j].a) << (T_W - 1 - j);
            c_dv[j] = r_dv[j];
            if (trial <= LIM_W'(r_dv[j].rem)) begin
                c_dv[j].rem = r_dv[j].rem - trial[NN_W-1:0];
                c_dv[j].t   = r_dv[j].t | (T_W'(1) << (T_W - 1 - j));
            end
        end
    end

    // Arithmetic shift gives the floor of t * d / 2^FRAC_BITS.
    always_comb begin
        c11_vx = LERP_W'(r10_bx) + (r10_tx >>> FRAC_BITS);
        c11_vy = LERP_W'(r10_by) + (r10_ty >>> FRAC_BITS);
        if (c11_vx[LERP_W-1:COORD_W-1] == '0 || c11_vx[LERP_W-1:COORD_W-1] == '1) begin
            c11_px = c11_vx[COORD_W-1:0];
        end else begin
            c11_px = c11_vx[LERP_W-1] ? {1'b1, {(COORD_W-1){1'b0}}}
                                      : {1'b0, {(COORD_W-1){1'b1}}};
        end
        if (c11_vy[LERP_W-1:COORD_W-1] == '0 || c11_vy[LERP_W-1:COORD_W-1] == '1) begin
            c11_py = c11_vy[COORD_W-1:0];
        end else begin
            c11_py = c11_vy[LERP_W-1] ? {1'b1, {(COORD_W-1){1'b0}}}
                                      : {1'b0, {(COORD_W-1){1'b1}}};
        end
    end

    assign c12_sqx = SQ_W'(r11_px) * SQ_W'(r11_px);
    assign c12_sqy = SQ_W'(r11_py) * SQ_W'(r11_py);

    always_comb begin
        c13_nm.miss  = r12_miss;
        c13_nm.lzero = (r12_sqx == '0) && (r12_sqy == '0);
        c13_nm.px    = r12_px;
        c13_nm.py    = r12_py;
        c13_nm.len2  = r12_sqx + r12_sqy;
        c13_nm.rx    = NR_W'(r12_sqx) << (2 * NORM_FRAC);
        c13_nm.ry    = NR_W'(r12_sqy) << (2 * NORM_FRAC);
        c13_nm.ppx   = '0;
        c13_nm.ppy   = '0;
        c13_nm.nx    = '0;
        c13_nm.ny    = '0;
    end

    // Largest n with n^2 * |p|^2 <= c^2 * 2^(2*NORM_FRAC), one bit per stage.
    // rx holds the remaining slack and ppx holds n * |p|^2.
    always_comb begin
        logic [NT_W-1:0] tx, ty, inc;
        for (int j = 0; j < NS; j++) begin
            inc     = NT_W'(r_nm[j].len2) << (2 * (NORM_FRAC - j));
            tx      = (NT_W'(r_nm[j].ppx) << (NORM_FRAC - j + 1)) + inc;
            ty      = (NT_W'(r_nm[j].ppy) << (NORM_FRAC - j + 1)) + inc;
            c_nm[j] = r_nm[j];
            if (tx <= NT_W'(r_nm[j].rx)) begin
                c_nm[j].rx  = r_nm[j].rx - tx[NR_W-1:0];
                c_nm[j].ppx = r_nm[j].ppx + (NP_W'(r_nm[j].len2) << (NORM_FRAC - j));
                c_nm[j].nx  = r_nm[j].nx | (NN_BITS'(1) << (NORM_FRAC - j));
            end
            if (ty <= NT_W'(r_nm[j].ry)) begin
                c_nm[j].ry  = r_nm[j].ry - ty[NR_W-1:0];
                c_nm[j].ppy = r_nm[j].ppy + (NP_W'(r_nm[j].len2) << (NORM_FRAC - j));
                c_nm[j].ny  = r_nm[j].ny | (NN_BITS'(1) << (NORM_FRAC - j));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r8_miss <= c8_miss;
            r8_n    <= c8_n;
            r8_lim  <= (LIM_W'(w_sq_side.a) << FRAC_BITS) + (LIM_W'(w_sq_side.a) << 1);
            r8_a    <= w_sq_side.a;
            r8_bx   <= w_sq_side.bx;
            r8_by   <= w_sq_side.by;
            r8_dx   <= w_sq_side.dx;
            r8_dy   <= w_sq_side.dy;

            r_dv[0] <= c9_dv;
            for (int j = 0; j < T_W; j++) begin
                r_dv[j+1] <= c_dv[j];
            end

            r10_miss <= r_dv[T_W].miss;
            r10_tx   <= LERP_W'($signed({1'b0, r_dv[T_W].t})) * LERP_W'($signed(r_dv[T_W].dx));
            r10_ty   <= LERP_W'($signed({1'b0, r_dv[T_W].t})) * LERP_W'($signed(r_dv[T_W].dy));
            r10_bx   <= r_dv[T_W].bx;
            r10_by   <= r_dv[T_W].by;

            r11_miss <= r10_miss;
            r11_px   <= c11_px;
            r11_py   <= c11_py;

            r12_miss <= r11_miss;
            r12_sqx  <= c12_sqx;
            r12_sqy  <= c12_sqy;
            r12_px   <= r11_px;
            r12_py   <= r11_py;

            r_nm[0] <= c13_nm;
            for (int j = 0; j < NS; j++) begin
                r_nm[j+1] <= c_nm[j];
            end
        end
    end

    always_comb begin
        if (r_nm[NS].miss || r_nm[NS].lzero) begin
            c_out_nx = '0;
            c_out_ny = '0;
        end else begin
            c_out_nx = r_nm[NS].px[COORD_W-1] ? -NORM_W'(r_nm[NS].nx) : NORM_W'(r_nm[NS].nx);
            c_out_ny = r_nm[NS].py[COORD_W-1] ? -NORM_W'(r_nm[NS].ny) : NORM_W'(r_nm[NS].ny);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= w_last_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_hit <= !r_nm[NS].miss;
            r_out_px  <= r_nm[NS].miss ? '0 : r_nm[NS].px;
            r_out_py  <= r_nm[NS].miss ? '0 : r_nm[NS].py;
            r_out_nx  <= c_out_nx;
            r_out_ny  <= c_out_ny;
        end
    end

    assign o_res.valid    = r_out_valid;
    assign o_res.hit      = r_out_hit;
    assign o_res.point_x  = r_out_px;
    assign o_res.point_y  = r_out_py;
    assign o_res.normal_x = r_out_nx;
    assign o_res.normal_y = r_out_ny;

`ifndef SYNTHESIS
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && !o_res.hit |-> o_res.point_x == 0 && o_res.point_y == 0
            && o_res.normal_x == 0 && o_res.normal_y == 0)
        else $error("miss transaction carries nonzero fields");

    a_normal_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> o_res.normal_x <= 16'sd16384 && o_res.normal_x >= -16'sd16384
            && o_res.normal_y <= 16'sd16384 && o_res.normal_y >= -16'sd16384)
        else $error("normal component beyond unit length");

    a_origin_normal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.hit && o_res.point_x == 0 && o_res.point_y == 0
            |-> o_res.normal_x == 0 && o_res.normal_y == 0)
        else $error("hit at the origin with nonzero normal");

    a_t_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dvv[T_W] && !r_dv[T_W].miss
            |-> r_dv[T_W].t <= (T_W'(1) << FRAC_BITS) + T_W'(1))
        else $error("root parameter beyond end of segment");
`endif

endmodule

/* tb/sv/sci_checker.sv */
module sci_checker import sci_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [RADIUS_W-1:0] i_cfg_wdata,
    sci_seg_if                  seg,
    sci_res_if                  res,
    output int                  o_errors,
    output int                  o_pending
);

    typedef struct packed {
        logic                      hit;
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic signed [NORM_W-1:0]  normal_x;
        logic signed [NORM_W-1:0]  normal_y;
    } t_hit_result;

    t_hit_result          hits_due[$];
    logic [RADIUS_W-1:0]  radius_q;

    function automatic logic [255:0] abs_wide(logic signed [127:0] v);
        logic [255:0] m;
        m = '0;
        m[127:0] = (v < 0) ? -v : v;
        return m;
    endfunction

    // Largest n below 2^15 with n^2 * |p|^2 <= c^2 * 2^28, signed like c.
    function automatic logic signed [NORM_W-1:0] unit_axis(logic signed [127:0] c,
                                                           logic [255:0] len2);
        logic [255:0] lhs;
        logic [255:0] cand;
        logic [255:0] nv;
        lhs = (abs_wide(c) * abs_wide(c)) << (2 * NORM_FRAC);
        nv = '0;
        for (int k = NORM_FRAC; k >= 0; k--) begin
            cand = nv | (256'd1 << k);
            if (cand * cand * len2 <= lhs) nv = cand;
        end
        return (c < 0) ? -$signed(nv[NORM_W-1:0]) : $signed(nv[NORM_W-1:0]);
    endfunction

    function automatic logic signed [COORD_W-1:0] clamp_coord(logic signed [127:0] v);
        logic signed [127:0] hi;
        logic signed [127:0] lo;
        hi = (128'sd1 <<< (COORD_W - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) return hi[COORD_W-1:0];
        if (v < lo) return lo[COORD_W-1:0];
        return v[COORD_W-1:0];
    endfunction

    function automatic t_hit_result entry_point(logic signed [COORD_W-1:0] bx,
                                                logic signed [COORD_W-1:0] by,
                                                logic signed [COORD_W-1:0] ex,
                                                logic signed [COORD_W-1:0] ey,
                                                logic [RADIUS_W-1:0] rad);
        logic signed [127:0] bxw, byw, dxw, dyw, bs, tw, pxw, pyw;
        logic [255:0] a, bmag, cpos, r2, cm, b2, ac, dsc, root, cand, n, nn, lim, t, len2;
        logic bneg;
        logic cneg;
        t_hit_result r;
        r = '0;
        bxw = bx;
        byw = by;
        dxw = $signed(ex) - bxw;
        dyw = $signed(ey) - byw;
        a = abs_wide(dxw) * abs_wide(dxw) + abs_wide(dyw) * abs_wide(dyw);
        if (a == 0) return r;
        bs = bxw * dxw + byw * dyw;
        bneg = bs < 0;
        bmag = abs_wide(bs);
        cpos = abs_wide(bxw) * abs_wide(bxw) + abs_wide(byw) * abs_wide(byw);
        r2 = '0;
        r2[RADIUS_W-1:0] = rad;
        r2 = r2 * r2;
        cneg = cpos < r2;
        cm = cneg ? r2 - cpos : cpos - r2;
        b2 = bmag * bmag;
        ac = a * cm;
        if (cneg) begin
            dsc = b2 + ac;
        end else begin
            if (b2 < ac) return r;
            dsc = b2 - ac;
        end
        root = '0;
        for (int k = 127; k >= 0; k--) begin
            cand = root | (256'd1 << k);
            if (cand * cand <= dsc) root = cand;
        end
        if (!bneg) begin
            // Only a segment starting at the circle and tangent to it passes here.
            if (bmag != 0 || root != 0) return r;
            n = '0;
        end else begin
            if (root > bmag) return r;
            n = bmag - root;
        end
        nn = n << FRAC_BITS;
        lim = a * ((256'd1 << FRAC_BITS) + 256'd2);
        if (nn >= lim) return r;
        t = nn / a;
        tw = '0;
        tw[T_W-1:0] = t[T_W-1:0];
        pxw = bxw + ((tw * dxw) >>> FRAC_BITS);
        pyw = byw + ((tw * dyw) >>> FRAC_BITS);
        r.hit = 1'b1;
        r.point_x = clamp_coord(pxw);
        r.point_y = clamp_coord(pyw);
        pxw = r.point_x;
        pyw = r.point_y;
        len2 = abs_wide(pxw) * abs_wide(pxw) + abs_wide(pyw) * abs_wide(pyw);
        if (len2 != 0) begin
            r.normal_x = unit_axis(pxw, len2);
            r.normal_y = unit_axis(pyw, len2);
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_hit_result want;
        int fails;
        fails = 0;
        if (!i_rst_n) begin
            radius_q <= RADIUS_RESET;
        end else begin
            if (i_cfg_we) radius_q <= i_cfg_wdata;
            if (seg.valid && seg.ready)
                hits_due = {hits_due, entry_point(seg.begin_x, seg.begin_y,
                                                  seg.end_x, seg.end_y, radius_q)};
            if (res.valid && res.ready) begin
                if (hits_due.size() == 0) begin
                    $error("result transaction with nothing expected");
                    fails++;
                end else begin
                    want = hits_due.pop_front();
                    if (res.hit !== want.hit) begin
                        $error("hit: expected %0d, got %0d", want.hit, res.hit);
                        fails++;
                    end
                    if (res.point_x !== want.point_x) begin
                        $error("point_x: expected %0d, got %0d", want.point_x, res.point_x);
                        fails++;
                    end
                    if (res.point_y !== want.point_y) begin
                        $error("point_y: expected %0d, got %0d", want.point_y, res.point_y);
                        fails++;
                    end
                    if (res.normal_x !== want.normal_x) begin
                        $error("normal_x: expected %0d, got %0d", want.normal_x,
                               res.normal_x);
                        fails++;
                    end
                    if (res.normal_y !== want.normal_y) begin
                        $error("normal_y: expected %0d, got %0d", want.normal_y,
                               res.normal_y);
                        fails++;
                    end
                end
            end
        end
        if (fails != 0) o_errors <= o_errors + fails;
        o_pending <= hits_due.size();
    end

endmodule

/* tb/sv/segment_circle_intersection_tb.sv */
module segment_circle_intersection_tb;
    import sci_pkg::*;

    localparam int PIPE_DEPTH  = 112;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int ONE         = 1 << FRAC_BITS;
    localparam logic signed [COORD_W-1:0] CMAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic signed [COORD_W-1:0] CMIN = {1'b1, {(COORD_W-1){1'b0}}};

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_we;
    logic [RADIUS_W-1:0] i_cfg_wdata;
    int                  errors;
    int                  pending;
    int                  cycles;
    logic                hold_request;
    logic [RADIUS_W-1:0] radius_now;

    sci_seg_if seg ();
    sci_res_if res ();

    segment_circle_intersection u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_seg       (seg),
        .o_res       (res)
    );

    sci_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .seg         (seg),
        .res         (res),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    function automatic int gap_length();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 55) return 0;
        if (pick < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Signed value in [-span, span]; span 0 means the whole coordinate range.
    function automatic logic signed [COORD_W-1:0] coord_near(longint span);
        longint v;
        if (span <= 0) return $urandom;
        v = longint'({$urandom, $urandom}) % (span + 1);
        if (v < 0) v = -v;
        if ($urandom_range(0, 1)) v = -v;
        if (v > longint'(CMAX)) v = longint'(CMAX);
        if (v < longint'(CMIN)) v = longint'(CMIN);
        return COORD_W'(v);
    endfunction

    task automatic send_segment(logic signed [COORD_W-1:0] bx, logic signed [COORD_W-1:0] by,
                                logic signed [COORD_W-1:0] ex, logic signed [COORD_W-1:0] ey);
        int gap;
        seg.valid   <= 1'b1;
        seg.begin_x <= bx;
        seg.begin_y <= by;
        seg.end_x   <= ex;
        seg.end_y   <= ey;
        @(posedge i_clk);
        while (!seg.ready) @(posedge i_clk);
        gap = gap_length();
        if (gap > 0) begin
            seg.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain_and_write(logic [RADIUS_W-1:0] value);
        seg.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (PIPE_DEPTH + 8) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        radius_now  = value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic random_segments(int count);
        longint r;
        longint span;
        logic signed [COORD_W-1:0] bx, by, ex, ey;
        for (int i = 0; i < count; i++) begin
            r = (radius_now == 0) ? ONE : longint'(radius_now);
            span = r * 3;
            bx = coord_near(span);
            by = coord_near(span);
            case ($urandom_range(0, 9))
                0, 1: begin
                    ex = $urandom;
                    ey = $urandom;
                    bx = $urandom;
                    by = $urandom;
                end
                2: begin
                    ex = bx;
                    ey = by;
                end
                3: begin
                    // Begin near the center, inside the circle unless the radius is zero.
                    bx = coord_near(r / 2);
                    by = coord_near(r / 2);
                    ex = coord_near(span);
                    ey = coord_near(span);
                end
                default: begin
                    // Through the neighborhood of the center from the far side.
                    ex = coord_near(r / 2) - bx;
                    ey = coord_near(r / 2) - by;
                    if ($urandom_range(0, 3) == 0) begin
                        ex = COORD_W'((longint'(ex) + longint'(bx)) / 2);
                        ey = COORD_W'((longint'(ey) + longint'(by)) / 2);
                    end
                end
            endcase
            send_segment(bx, by, ex, ey);
        end
    endtask

    // Receiver: random ready pattern, with one long hold-off on request.
    initial begin
        int run;
        bit held;
        res.ready = 1'b0;
        held = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_request && !held) begin
                res.ready <= 1'b0;
                repeat (1000) @(posedge i_clk);
                held = 1'b1;
            end else if ($urandom_range(0, 9) < 6) begin
                res.ready <= 1'b1;
                run = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(1, 20);
                repeat (run) @(posedge i_clk);
            end else begin
                res.ready <= 1'b0;
                run = gap_length() + 1;
                repeat (run) @(posedge i_clk);
            end
        end
    end

    initial begin
        logic [RADIUS_W-1:0] radii [4];
        hold_request = 1'b0;
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_wdata  = '0;
        radius_now   = RADIUS_RESET;
        seg.valid    = 1'b0;
        seg.begin_x  = '0;
        seg.begin_y  = '0;
        seg.end_x    = '0;
        seg.end_y    = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Unit circle out of reset.
        send_segment(0, 0, 0, 0);
        send_segment(-2 * ONE, 0, 2 * ONE, 0);
        send_segment(0, 0, 2 * ONE, 0);
        send_segment(-2 * ONE, 2 * ONE, 2 * ONE, 2 * ONE);
        send_segment(2 * ONE, 0, 4 * ONE, 0);
        send_segment(-2 * ONE, 0, -ONE, 0);
        send_segment(-2 * ONE, 0, -ONE - 1, 0);
        send_segment(-2 * ONE, ONE, 2 * ONE, ONE);
        send_segment(ONE, 0, 3 * ONE, 0);
        send_segment(0, 3 * ONE, 0, -3 * ONE);
        send_segment(CMIN, CMIN, CMAX, CMAX);
        send_segment(CMAX, CMAX, CMIN, CMIN);
        send_segment(CMIN, 0, CMAX, 0);
        send_segment(0, CMIN, 0, CMAX);
        send_segment(CMAX, CMIN, CMIN, CMAX);
        send_segment(-1, -1, -1, -1);

        drain_and_write(RADIUS_RESET);
        random_segments(250);

        // Degenerate circle: the hit point is the origin.
        drain_and_write('0);
        send_segment(-ONE, 0, ONE, 0);
        send_segment(-ONE, -ONE, ONE, ONE);
        send_segment(0, 0, ONE, 0);
        random_segments(200);

        drain_and_write({RADIUS_W{1'b1}});
        send_segment(CMIN, 0, CMAX, 0);
        send_segment(CMIN, CMIN, CMAX, CMAX);
        send_segment(CMAX, CMAX, CMAX - ONE, CMAX);
        random_segments(250);

        radii[0] = RADIUS_W'(1);
        radii[1] = RADIUS_W'($urandom_range(ONE, 64 * ONE));
        radii[2] = RADIUS_W'($urandom);
        radii[3] = RADIUS_W'($urandom_range(1, ONE));
        for (int p = 0; p < 4; p++) begin
            drain_and_write(radii[p]);
            if (p == 1) hold_request = 1'b1;
            random_segments(300);
        end

        seg.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (PIPE_DEPTH + 8) @(posedge i_clk);
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
